/* design/fadd_pkg.sv */
// shared types and constants for the force assist dead band damper
package fadd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSIST_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICTION_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSIST_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_FILTER_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN        = 3'd4;

    localparam int CFG_DATA_W = 16;

    // reset values
    localparam logic [14:0] RST_ASSIST_THRESHOLD  = 15'd1300;
    localparam logic [14:0] RST_STICTION_OFFSET   = 15'd600;
    localparam logic [15:0] RST_ASSIST_GAIN       = 16'd0;
    localparam logic [15:0] RST_DERIV_FILTER_COEF = 16'd6554;
    localparam logic [15:0] RST_DERIV_GAIN        = 16'd0;

    // serial multiplier: a times b, one bit of b per cycle
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // serial divider: restoring, one quotient bit per cycle
    localparam int DIV_N_W   = 24;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    typedef struct packed {
        logic [14:0]        assist_threshold;
        logic [14:0]        stiction_offset;
        logic signed [15:0] assist_gain;
        logic [15:0]        deriv_filter_coef;
        logic signed [15:0] deriv_gain;
    } fadd_cfg_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } fadd_mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } fadd_div_req_t;

endpackage

/* design/force_assist_deadband_damper.sv */
// top level: force assist with dead band, stiction offset and derivative damping
//
// usage
//   s_axis carries one sample word: force_applied and time_step. one result
//   word leaves on m_axis per sample: the saturated assist_force.
//   cfg_* writes one of the five registers (index 0..4); cfg_ready is always
//   high, other indexes are dropped. write registers only while idle.
// sequence
//   one sample runs through load, four multiplies on the shared bit-serial
//   multiplier (one multiplier bit per cycle, 17 bits each), the division by
//   time_step on the restoring divider between the first and second multiply,
//   and the combine and rounding steps. s_axis_tready is high only between
//   samples, so a new sample is taken only once the last one is through.
// stall
//   the result sits in an output register; a new sample is taken while it
//   waits. if the next result is ready before the old one is taken, the
//   sequencer holds in its last step until m_axis_tready frees the register.
// reset
//   registers return to their defaults, previous force and filtered
//   derivative clear to zero, both channels go idle.
module force_assist_deadband_damper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // sample words
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [31:0]                          s_axis_tdata,  // force_applied[15:0], time_step[31:16]
    // result words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // assist_force[15:0]
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fadd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fadd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fadd_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_T1     = 4'd2;  // coef * |delta|
    localparam logic [3:0] ST_DIV    = 4'd3;  // divide by time step
    localparam logic [3:0] ST_T2     = 4'd4;  // (1 - coef) * |last derivative|
    localparam logic [3:0] ST_BASE   = 4'd5;  // |gain| * |force|
    localparam logic [3:0] ST_DMP    = 4'd6;  // |deriv gain| * |derivative|
    localparam logic [3:0] ST_TOTAL  = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    fadd_cfg_t     cfg;
    fadd_mul_req_t mul_req;
    fadd_div_req_t div_req;
    logic                 mul_done;
    logic [MUL_P_W-1:0]   mul_product;
    logic                 div_done;
    logic [DIV_N_W-1:0]   div_quotient;

    logic [3:0]         state_reg, state_next;
    logic signed [15:0] f_reg, f_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [15:0] last_force_reg, last_force_next;
    logic signed [31:0] last_deriv_reg, last_deriv_next;
    logic               delta_neg_reg, delta_neg_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [32:0] base_reg, base_next;
    logic signed [47:0] dmp_reg, dmp_next;
    logic signed [49:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg, out_data_next;

    logic               in_accept;
    logic signed [16:0] delta;
    logic [16:0]        delta_mag;
    logic [16:0]        f_mag;
    logic [16:0]        gain_mag;
    logic [16:0]        dg_mag;
    logic [31:0]        ld_mag;
    logic [31:0]        d_mag;
    logic [16:0]        coef_comp;
    logic [15:0]        dt_eff;
    logic signed [34:0] t1_ext;
    logic signed [34:0] t2_ext;
    logic signed [34:0] d_sum;
    logic signed [31:0] d_sat;
    logic signed [32:0] gf_mag;
    logic signed [32:0] gf;
    logic signed [32:0] off_q12;
    logic signed [32:0] base_val;
    logic [47:0]        dmp_mag;
    logic signed [49:0] rnd;
    logic signed [29:0] q_out;
    logic [15:0]        r_sat;

    fadd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fadd_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    fadd_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // operand magnitudes, signs are put back after each product
    always_comb
    begin
        delta     = {f_reg[15], f_reg} - {last_force_reg[15], last_force_reg};
        delta_mag = delta[16] ? 17'(-delta) : 17'(delta);
        f_mag     = f_reg[15] ? 17'(-{f_reg[15], f_reg}) : {1'b0, f_reg};
        gain_mag  = cfg.assist_gain[15] ? 17'(-{cfg.assist_gain[15], cfg.assist_gain})
                                        : {1'b0, cfg.assist_gain};
        dg_mag    = cfg.deriv_gain[15] ? 17'(-{cfg.deriv_gain[15], cfg.deriv_gain})
                                       : {1'b0, cfg.deriv_gain};
        ld_mag    = last_deriv_reg[31] ? (~last_deriv_reg + 32'd1) : last_deriv_reg;
        d_mag     = d_reg[31] ? (~d_reg + 32'd1) : d_reg;
        coef_comp = 17'h10000 - {1'b0, cfg.deriv_filter_coef};
        dt_eff    = (dt_reg == 16'd0) ? 16'd1 : dt_reg;
    end

    // filtered derivative: t1 from the divider, t2 from the multiplier
    always_comb
    begin
        t1_ext = delta_neg_reg ? -$signed({11'd0, div_quotient})
                               :  $signed({11'd0, div_quotient});
        t2_ext = last_deriv_reg[31] ? -$signed({2'b00, mul_product[48:16]})
                                    :  $signed({2'b00, mul_product[48:16]});
        d_sum  = t1_ext + t2_ext;
        if ((d_sum[34:31] == 4'b0000) || (d_sum[34:31] == 4'b1111))
        begin
            d_sat = d_sum[31:0];
        end
        else if (d_sum[34])
        begin
            d_sat = 32'sh8000_0000;
        end
        else
        begin
            d_sat = 32'sh7fff_ffff;
        end
    end

    // base term with dead band and stiction offset
    always_comb
    begin
        gf_mag  = $signed({1'b0, mul_product[31:0]});
        gf      = (cfg.assist_gain[15] ^ f_reg[15]) ? -gf_mag : gf_mag;
        off_q12 = $signed({6'd0, cfg.stiction_offset, 12'd0});
        base_val = -gf;
        if (f_reg[15])
        begin
            base_val = -gf + off_q12;
        end
        else if (f_reg != 16'sd0)
        begin
            base_val = -gf - off_q12;
        end
        if (f_mag < {2'b00, cfg.assist_threshold})
        begin
            base_val = '0;
        end
    end

    // damping product magnitude, then rounding toward zero and saturation
    always_comb
    begin
        dmp_mag = mul_product[47:0];
        rnd     = total_reg + (total_reg[49] ? 50'sd1048575 : 50'sd0);
        q_out   = rnd[49:20];
        if ((q_out[29:15] == '0) || (q_out[29:15] == '1))
        begin
            r_sat = q_out[15:0];
        end
        else if (q_out[29])
        begin
            r_sat = 16'h8000;
        end
        else
        begin
            r_sat = 16'h7fff;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        f_next          = f_reg;
        dt_next         = dt_reg;
        last_force_next = last_force_reg;
        last_deriv_next = last_deriv_reg;
        delta_neg_next  = delta_neg_reg;
        d_next          = d_reg;
        base_next       = base_reg;
        dmp_next        = dmp_reg;
        total_next      = total_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        mul_req         = '0;
        div_req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    f_next     = $signed(s_axis_tdata[15:0]);
                    dt_next    = s_axis_tdata[31:16];
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mul_req.start   = 1'b1;
                mul_req.a       = MUL_A_W'(delta_mag);
                mul_req.b       = {1'b0, cfg.deriv_filter_coef};
                delta_neg_next  = delta[16];
                last_force_next = f_reg;
                state_next      = ST_T1;
            end
            ST_T1:
            begin
                if (mul_done)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_product[31:8];
                    div_req.den   = dt_eff;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = ld_mag;
                    mul_req.b     = coef_comp;
                    state_next    = ST_T2;
                end
            end
            ST_T2:
            begin
                if (mul_done)
                begin
                    d_next          = d_sat;
                    last_deriv_next = d_sat;
                    mul_req.start   = 1'b1;
                    mul_req.a       = MUL_A_W'(f_mag);
                    mul_req.b       = gain_mag;
                    state_next      = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (mul_done)
                begin
                    base_next     = base_val;
                    mul_req.start = 1'b1;
                    mul_req.a     = d_mag;
                    mul_req.b     = dg_mag;
                    state_next    = ST_DMP;
                end
            end
            ST_DMP:
            begin
                if (mul_done)
                begin
                    dmp_next   = (cfg.deriv_gain[15] ^ d_reg[31]) ? -$signed(dmp_mag)
                                                                  :  $signed(dmp_mag);
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL:
            begin
                total_next = $signed({{9{base_reg[32]}}, base_reg, 8'd0})
                           - $signed({{2{dmp_reg[47]}}, dmp_reg});
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait here while an untaken result still fills the output register
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = r_sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_force_reg <= '0;
            last_deriv_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_force_reg <= last_force_next;
            last_deriv_reg <= last_deriv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg         <= f_next;
        dt_reg        <= dt_next;
        delta_neg_reg <= delta_neg_next;
        d_reg         <= d_next;
        base_reg      <= base_next;
        dmp_reg       <= dmp_next;
        total_reg     <= total_next;
        out_data_reg  <= out_data_next;
    end

endmodule

/* design/fadd_cfg_regs.sv */
// configuration register file
module fadd_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [fadd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fadd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output fadd_pkg::fadd_cfg_t                  cfg
);
    import fadd_pkg::*;

    fadd_cfg_t cfg_reg;
    fadd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ASSIST_THRESHOLD:  cfg_next.assist_threshold  = cfg_data[14:0];
                CFG_STICTION_OFFSET:   cfg_next.stiction_offset   = cfg_data[14:0];
                CFG_ASSIST_GAIN:       cfg_next.assist_gain       = $signed(cfg_data);
                CFG_DERIV_FILTER_COEF: cfg_next.deriv_filter_coef = cfg_data;
                CFG_DERIV_GAIN:        cfg_next.deriv_gain        = $signed(cfg_data);
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.assist_threshold  <= RST_ASSIST_THRESHOLD;
            cfg_reg.stiction_offset   <= RST_STICTION_OFFSET;
            cfg_reg.assist_gain       <= $signed(RST_ASSIST_GAIN);
            cfg_reg.deriv_filter_coef <= RST_DERIV_FILTER_COEF;
            cfg_reg.deriv_gain        <= $signed(RST_DERIV_GAIN);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/fadd_serial_mul.sv */
// bit-serial shift-add multiplier, unsigned operands
module fadd_serial_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fadd_pkg::fadd_mul_req_t       req,
    output logic                          done,
    output logic [fadd_pkg::MUL_P_W-1:0]  product
);
    import fadd_pkg::*;

    logic [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_P_W-1:0]   prod_reg, prod_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [MUL_A_W-1:0]   addend;
    logic [MUL_A_W:0]     sum;

    // low part of prod_reg holds the multiplier bits still to be consumed
    always_comb
    begin
        addend      = prod_reg[0] ? a_reg : '0;
        sum         = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]} + {1'b0, addend};
        a_next      = a_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            a_next      = req.a;
            prod_next   = {{MUL_A_W{1'b0}}, req.b};
            cnt_next    = MUL_CNT_W'(MUL_B_W);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            prod_next = {sum, prod_reg[MUL_B_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

/* design/fadd_serial_div.sv */
// restoring divider, one quotient bit per cycle
module fadd_serial_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fadd_pkg::fadd_div_req_t       req,
    output logic                          done,
    output logic [fadd_pkg::DIV_N_W-1:0]  quotient
);
    import fadd_pkg::*;

    logic [DIV_D_W-1:0]   den_reg, den_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   diff;

    // quo_reg shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb
    begin
        shifted     = {rem_reg, quo_reg[DIV_N_W-1]};
        diff        = {1'b0, shifted} - {2'b00, den_reg};
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            den_next    = req.den;
            rem_next    = '0;
            quo_next    = req.num;
            cnt_next    = DIV_CNT_W'(DIV_N_W);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (diff[DIV_D_W+1])
            begin
                rem_next = shifted[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/fadd_checker.sv */
// port-level checker for the force assist damper, bound to the top level
module fadd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a result word stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped before it was taken");

    // a stalled result word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // one sample at a time: busy right after a sample is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample taken while previous one still in work");

    // no result can appear the cycle after a sample is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result word appeared too early after a sample");

endmodule

bind force_assist_deadband_damper fadd_checker u_fadd_checker (.*);

/* test/force_assist_deadband_damper_test.sv */
// testbench for the force assist dead band damper: predicted assist force against the result stream
module force_assist_deadband_damper_test;

    timeunit 1ns;
    timeprecision 1ps;

    // indexes that map to no register, writes there must be dropped
    localparam logic [fadd_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [fadd_pkg::CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 3'd7;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 125;
    localparam int HOLD_AFTER_ITEMS = 300;   // sample count that starts the long receiver hold
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 20;
    localparam int TAIL_CYCLES      = 200;

    // predicts the assist force word for each accepted sample and keeps the
    // expected words in acceptance order
    class assist_force_tracker;
        localparam longint DERIV_MAX = 64'sd2147483647;
        localparam longint DERIV_MIN = -64'sd2147483648;
        localparam longint OUT_MAX   = 64'sd32767;
        localparam longint OUT_MIN   = -64'sd32768;

        logic [14:0]        thr;
        logic [14:0]        stiction;
        logic signed [15:0] gain;
        logic [15:0]        coef;
        logic signed [15:0] dgain;
        longint             prev_force;
        longint             prev_deriv;
        logic [15:0]        expected_assist[$];
        int                 errors;

        function new();
            thr        = fadd_pkg::RST_ASSIST_THRESHOLD;
            stiction   = fadd_pkg::RST_STICTION_OFFSET;
            gain       = fadd_pkg::RST_ASSIST_GAIN;
            coef       = fadd_pkg::RST_DERIV_FILTER_COEF;
            dgain      = fadd_pkg::RST_DERIV_GAIN;
            prev_force = 0;
            prev_deriv = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [fadd_pkg::CFG_IDX_W-1:0] idx,
                              logic [fadd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fadd_pkg::CFG_ASSIST_THRESHOLD:  thr      = data[14:0];
                fadd_pkg::CFG_STICTION_OFFSET:   stiction = data[14:0];
                fadd_pkg::CFG_ASSIST_GAIN:       gain     = data;
                fadd_pkg::CFG_DERIV_FILTER_COEF: coef     = data;
                fadd_pkg::CFG_DERIV_GAIN:        dgain    = data;
                default: ;
            endcase
        endfunction

        // one step of the damper, updates previous force and derivative
        function logic [15:0] predict_assist(logic signed [15:0] force_in, logic [15:0] step);
            longint f, dt, mag, base, delta, t1, t2, d, total, r;
            f  = force_in;
            dt = longint'(step);
            if (dt == 0)
                dt = 1;
            mag  = (f < 0) ? -f : f;
            base = 0;
            if (mag >= longint'(thr))
            begin
                base = -(longint'(gain) * f);
                // offset opposes the force, nothing for a zero force
                if (f < 0)
                    base = base + longint'(stiction) * 4096;
                else if (f > 0)
                    base = base - longint'(stiction) * 4096;
            end
            delta = f - prev_force;
            t1 = (longint'(coef) * delta) / (256 * dt);
            t2 = ((65536 - longint'(coef)) * prev_deriv) / 65536;
            d  = t1 + t2;
            if (d > DERIV_MAX)
                d = DERIV_MAX;
            if (d < DERIV_MIN)
                d = DERIV_MIN;
            total = base * 256 - longint'(dgain) * d;
            r = total / 1048576;
            if (r > OUT_MAX)
                r = OUT_MAX;
            if (r < OUT_MIN)
                r = OUT_MIN;
            prev_force = f;
            prev_deriv = d;
            return r[15:0];
        endfunction

        function void note_sample(logic signed [15:0] force_in, logic [15:0] step);
            expected_assist.push_back(predict_assist(force_in, step));
        endfunction

        function void check_assist(logic [15:0] actual);
            logic [15:0] want;
            if (expected_assist.size() == 0)
            begin
                $display("%0t: unexpected assist_force word, expected none, actual %0d",
                         $time, $signed(actual));
                errors++;
            end
            else
            begin
                want = expected_assist.pop_front();
                if (want !== actual)
                begin
                    $display("%0t: assist_force expected %0d, actual %0d",
                             $time, $signed(want), $signed(actual));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_assist.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // force_applied[15:0], time_step[31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // assist_force[15:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [fadd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fadd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    assist_force_tracker tracker = new();

    int                 sent_count = 0;
    int                 burst_left = 0;
    bit                 long_hold_done = 1'b0;
    logic signed [15:0] prev_force = '0;

    force_assist_deadband_damper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // offer one sample word, bursts of random length with random gaps in between
    task automatic send_sample(input logic signed [15:0] f, input logic [15:0] dt);
        int gap;
        if (burst_left == 0)
        begin
            // mostly short gaps, now and then one long enough to span a whole sample
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dt, f};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_sample(f, dt);
        sent_count++;
        burst_left--;
    endtask

    // stop offering and wait for every expected word, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fadd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fadd_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // full register set, only once the block is idle
    task automatic apply_config(input logic [14:0] thr, input logic [14:0] stic,
                                input logic [15:0] gain, input logic [15:0] coef,
                                input logic [15:0] dgain);
        drain_results();
        // bit 15 of the 15-bit registers is random, it must be ignored
        write_reg(fadd_pkg::CFG_ASSIST_THRESHOLD, {1'($urandom_range(0, 1)), thr});
        write_reg(fadd_pkg::CFG_STICTION_OFFSET, {1'($urandom_range(0, 1)), stic});
        write_reg(fadd_pkg::CFG_ASSIST_GAIN, gain);
        write_reg(fadd_pkg::CFG_DERIV_FILTER_COEF, coef);
        write_reg(fadd_pkg::CFG_DERIV_GAIN, dgain);
    endtask

    function automatic logic [14:0] pick_u15();
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return 15'h7fff;
            2, 3: return 15'($urandom_range(0, 3000));
            default: return 15'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4, 5: return 16'(int'($urandom_range(0, 16383)) - 8192);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(3000, 10000));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] random_force();
        int t;
        case ($urandom_range(0, 9))
            0, 1: t = int'($urandom());
            2, 3:
            begin
                // around the dead band edge, either sign
                t = int'(tracker.thr) + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(0, 1))
                    t = -t;
            end
            4:
            begin
                case ($urandom_range(0, 4))
                    0: t = 32767;
                    1: t = -32768;
                    2: t = 0;
                    3: t = 1;
                    default: t = -1;
                endcase
            end
            5, 6: t = int'(prev_force) + int'($urandom_range(0, 600)) - 300;
            default: t = int'($urandom_range(0, 6000)) - 3000;
        endcase
        return t[15:0];
    endfunction

    function automatic logic [15:0] random_step();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'($urandom());
            2: return 16'd1;
            default: return 16'($urandom_range(1, 32));
        endcase
    endfunction

    // every accepted result word is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_assist(m_axis_tdata);
    end

    // receiver: own stall pattern, plus one long hold so the block fills and stalls its input
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && sent_count >= HOLD_AFTER_ITEMS)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 128);
                end
                left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;                           // no stalls
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) == 0);    // mostly stalled
                    default: m_axis_tready <= ((left % 5) != 0);        // periodic gaps
                endcase
            end
        end
    end

    // stimulus
    initial
    begin
        int phase;
        int i;
        logic signed [15:0] f;
        logic [15:0] dt;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults: zero gains, so only the sign logic runs
        send_sample(16'sd0, 16'd0);
        send_sample(16'sd1500, 16'd1);
        send_sample(-16'sd1500, 16'hffff);
        send_sample(16'sd100, 16'd3);

        // zero threshold, largest offset, most negative gain, full coefficient
        apply_config(15'd0, 15'h7fff, 16'h8000, 16'hffff, 16'h7fff);
        write_reg(CFG_LAST_UNUSED, 16'hffff);
        send_sample(16'sd0, 16'd0);          // zero force at zero threshold: no offset
        send_sample(16'sd32767, 16'd1);      // positive overflow
        send_sample(-16'sd32768, 16'd1);     // full swing of the derivative
        send_sample(16'sd1, 16'd0);
        send_sample(-16'sd1, 16'd65535);
        send_sample(16'sd0, 16'hffff);
        send_sample(16'sd32767, 16'd0);

        // largest threshold, no offset, most positive gain, derivative frozen
        apply_config(15'h7fff, 15'd0, 16'h7fff, 16'h0000, 16'h8000);
        send_sample(-16'sd32768, 16'd2);     // only magnitude above the largest threshold
        send_sample(16'sd32767, 16'd1);      // magnitude equal to the threshold
        send_sample(16'sd32766, 16'd1);      // just inside the dead band
        send_sample(-16'sd32767, 16'hffff);
        send_sample(16'sd0, 16'd0);

        // strong damping on a swinging force, output saturates both ways
        apply_config(15'd5, 15'd10, 16'h1000, 16'hffff, 16'h8000);
        send_sample(16'sd4, 16'd1);          // just below the threshold
        send_sample(16'sd5, 16'd1);          // at the threshold
        send_sample(16'sd32767, 16'd0);
        send_sample(-16'sd32768, 16'd0);
        send_sample(16'sd32767, 16'd0);

        // random settings, each followed by a stretch of random samples
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_config(pick_u15(), pick_u15(), pick_gain(), pick_coef(), pick_gain());
            if ($urandom_range(0, 1))
                write_reg(3'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                          16'($urandom()));
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                f  = random_force();
                dt = random_step();
                send_sample(f, dt);
                prev_force = f;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
